// ----- design/cbs_pkg.sv -----
// Shared types, constants and helpers for the connection beacon scorer.
package cbs_pkg;

  localparam int unsigned PROC_SLOTS = 16;
  localparam int unsigned PROC_W     = $clog2(PROC_SLOTS);
  localparam int unsigned ADDR_SLOTS = 11;
  localparam int unsigned ADDR_CNT_W = 4;
  localparam int unsigned ADDR_DEPTH = PROC_SLOTS * ADDR_SLOTS;
  localparam int unsigned ADDR_IDX_W = $clog2(ADDR_DEPTH);
  localparam int unsigned NUM_HOT    = 13;
  localparam int unsigned GAP_W      = 24;
  localparam int unsigned SCORE_W    = 7;
  localparam int unsigned PROD_W     = 88;

  localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};
  localparam int unsigned GAP_LO_K = 1000;
  localparam int unsigned GAP_HI_K = 3600000;
  localparam int unsigned CV_N_K   = 100;
  localparam int unsigned CV_S_K   = 109;
  localparam int unsigned MIN_GAPS = 5;
  localparam int unsigned MAX_SCORE = 100;
  localparam int unsigned BEACON_PTS = 60;

  localparam logic [15:0] HOT_PORTS [NUM_HOT] = '{
    16'd4444, 16'd5555, 16'd6666, 16'd6667, 16'd6668, 16'd7777, 16'd8080,
    16'd8443, 16'd9001, 16'd9002, 16'd31337, 16'd12345, 16'd65535
  };

  localparam logic [1:0] KIND_TRACK = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;
  localparam logic [1:0] KIND_LIST  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [1:0] STATUS_NOMATCH = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] proc_id;
    logic [31:0] dest_addr;
    logic [15:0] dest_port_num;
    logic [47:0] now_ms;
    logic [6:0]  score_floor;
  } req_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [31:0]        out_proc_id;
    logic               beacon_seen;
    logic [1:0]         status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [15:0]           conn_total;
    logic [47:0]           last_seen_ms;
    logic [15:0]           gap_count;
    logic [39:0]           gap_sum;
    logic [63:0]           gap_square_sum;
    logic [ADDR_CNT_W-1:0] addr_count;
    logic [NUM_HOT-1:0]    port_hit_mask;
  } stat_t;

  typedef struct packed {
    logic               done;
    logic               beacon;
    logic [SCORE_W-1:0] score;
  } sc_res_t;

  function automatic logic [NUM_HOT-1:0] hot_mask(input logic [15:0] port);
    logic [NUM_HOT-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_HOT; i++) begin
      if (HOT_PORTS[i] == port) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ----- design/cbs_scorer.sv -----
// Score unit: base points plus a serial shift-add beacon test on one entry.
module cbs_scorer import cbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  stat_t   stat_i,
  output sc_res_t result_o
);

  localparam logic [2:0] SC_IDLE  = 3'd0;
  localparam logic [2:0] SC_CHECK = 3'd1;
  localparam logic [2:0] SC_MUL1  = 3'd2;
  localparam logic [2:0] SC_MUL2  = 3'd3;
  localparam logic [2:0] SC_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  stat_t             st_q;
  logic              zero_q;
  logic [7:0]        base_q;
  logic              beacon_q;
  logic [PROD_W-1:0] ma_q, acc_q, lhs_q;
  logic [39:0]       mb_q;

  logic [3:0]  hits;
  logic [7:0]  conn_pts, addr_pts, base_d;
  logic [39:0] lo_lim, hi_lim;
  logic        range_ok;
  logic [22:0] n100;
  logic [46:0] s109;
  logic [8:0]  total;

  always_comb begin
    hits = '0;
    for (int i = 0; i < NUM_HOT; i++) begin
      hits = hits + 4'(st_q.port_hit_mask[i]);
    end
    if (st_q.conn_total > 16'd50) conn_pts = 8'd20;
    else if (st_q.conn_total > 16'd20) conn_pts = 8'd10;
    else conn_pts = 8'd0;
    if (st_q.addr_count > ADDR_CNT_W'(10)) addr_pts = 8'd25;
    else if (st_q.addr_count > ADDR_CNT_W'(5)) addr_pts = 8'd15;
    else if (st_q.addr_count == ADDR_CNT_W'(1) && st_q.conn_total > 16'd10) addr_pts = 8'd20;
    else addr_pts = 8'd0;
    base_d = conn_pts + 8'(hits) * 8'd15 + addr_pts;
    lo_lim = 40'(st_q.gap_count) * 40'(GAP_LO_K);
    hi_lim = 40'(st_q.gap_count) * 40'(GAP_HI_K);
    range_ok = (st_q.gap_count >= 16'(MIN_GAPS)) && (st_q.gap_sum > lo_lim) &&
               (st_q.gap_sum < hi_lim);
    n100 = 23'(st_q.gap_count) * 23'(CV_N_K);
    s109 = 47'(st_q.gap_sum) * 47'(CV_S_K);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SC_IDLE:  if (start_i) state_d = SC_CHECK;
      SC_CHECK: state_d = range_ok ? SC_MUL1 : SC_DONE;
      SC_MUL1:  if (mb_q == '0) state_d = SC_MUL2;
      SC_MUL2:  if (mb_q == '0) state_d = SC_DONE;
      SC_DONE:  state_d = SC_IDLE;
      default:  state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // n*100*Q first, then S*109*S; one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      SC_IDLE: begin
        if (start_i) st_q <= stat_i;
      end
      SC_CHECK: begin
        zero_q   <= st_q.conn_total < 16'd3;
        base_q   <= base_d;
        beacon_q <= 1'b0;
        ma_q     <= PROD_W'(st_q.gap_square_sum);
        mb_q     <= 40'(n100);
        acc_q    <= '0;
      end
      SC_MUL1, SC_MUL2: begin
        if (mb_q == '0) begin
          if (state_q == SC_MUL1) begin
            lhs_q <= acc_q;
            ma_q  <= PROD_W'(s109);
            mb_q  <= st_q.gap_sum;
            acc_q <= '0;
          end else begin
            beacon_q <= lhs_q < acc_q;
          end
        end else begin
          if (mb_q[0]) acc_q <= acc_q + ma_q;
          ma_q <= ma_q << 1;
          mb_q <= mb_q >> 1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    total = 9'(base_q) + (beacon_q ? 9'(BEACON_PTS) : 9'd0);
    result_o.done   = state_q == SC_DONE;
    result_o.beacon = beacon_q;
    if (zero_q) result_o.score = '0;
    else if (total > 9'(MAX_SCORE)) result_o.score = SCORE_W'(MAX_SCORE);
    else result_o.score = total[SCORE_W-1:0];
  end

endmodule

// ----- design/connection_beacon_scorer_core.sv -----
// Connection beacon scorer: per-process table, event update, score and list queries.
//
// Requests enter on in_valid_i/in_ready_o as one req_t; results leave on
// out_valid_o/out_ready_i as res_t. Kind track, query and free give one
// result; list gives one result per matching entry in ascending id order
// (at most 16), with last set on the final one, or a single no-match result.
// The block takes one request at a time; in_ready_o is high whenever no
// request is in work, even while the last result waits in the output register.
// Per-entry statistics sit in a 16-word memory and the address slots in a
// 176-word memory, both with registered read data.
// Track: lookup, statistics read, one compare per stored address, gap and
// update, then one score. Score: range check, then, when the beacon test
// runs, two multiplies on the serial shift-add multiplier in the scorer.
// List: one score per valid entry, then a scan of all slots per emitted result.
// Reset empties the table at once (valid flags are flip-flops).
// A stalled receiver holds the result in the output register; the next
// result waits until it is taken.
module connection_beacon_scorer_core import cbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_ACMP  = 4'd4;
  localparam logic [3:0] S_GAP   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_SCORE = 4'd7;
  localparam logic [3:0] S_SWAIT = 4'd8;
  localparam logic [3:0] S_LCHK  = 4'd9;
  localparam logic [3:0] S_LADV  = 4'd10;
  localparam logic [3:0] S_SEL   = 4'd11;
  localparam logic [3:0] S_LPICK = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic [PROC_W-1:0] LAST_IDX = PROC_W'(PROC_SLOTS - 1);

  logic [3:0]            state_q, state_d;
  req_t                  req_q;
  logic [PROC_W-1:0]     idx_q;
  logic                  new_q;
  stat_t                 cur_q;
  logic [ADDR_CNT_W-1:0] ai_q;
  logic                  seen_q;
  logic [GAP_W-1:0]      gap_q;
  logic [PROC_SLOTS-1:0] valid_q;
  logic [31:0]           key_q [PROC_SLOTS];
  logic [SCORE_W-1:0]    lsc_q [PROC_SLOTS];
  logic [PROC_SLOTS-1:0] lbc_q;
  logic [PROC_SLOTS-1:0] rem_q;
  logic [PROC_W-1:0]     j_q;
  logic                  best_ok_q;
  logic [PROC_W-1:0]     best_idx_q;
  logic [31:0]           best_key_q;
  logic [SCORE_W-1:0]    best_sc_q;
  logic                  best_bc_q;
  res_t                  res_q;
  res_t                  out_q;
  logic                  out_valid_q;

  stat_t                 stat_mem [PROC_SLOTS];
  stat_t                 stat_rd_q;
  logic [PROC_W-1:0]     stat_ra;
  logic                  stat_we;
  stat_t                 upd;

  logic [31:0]           addr_mem [ADDR_DEPTH];
  logic [31:0]           addr_rd_q;
  logic [ADDR_IDX_W-1:0] addr_base, addr_ra, addr_wa;
  logic                  addr_we;
  logic                  addr_new;

  logic                  hit_any, free_any;
  logic [PROC_W-1:0]     hit_idx, free_idx;
  logic [47:0]           diff;
  logic [GAP_W-1:0]      gap_d;
  logic [47:0]           gap_sq;
  logic                  cand;
  logic [PROC_SLOTS-1:0] rem_left;
  logic                  accept, out_load;
  sc_res_t               sc;

  function automatic res_t mk_res(input logic [SCORE_W-1:0] s, input logic [31:0] id,
                                  input logic b, input logic [1:0] st, input logic l);
    res_t r;
    r.score       = s;
    r.out_proc_id = id;
    r.beacon_seen = b;
    r.status      = st;
    r.last        = l;
    return r;
  endfunction

  assign in_ready_o  = state_q == S_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_load    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // lowest matching and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = PROC_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == req_q.proc_id) begin
        hit_any = 1'b1;
        hit_idx = PROC_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = PROC_W'(i);
      end
    end
  end

  always_comb begin
    diff  = req_q.now_ms - cur_q.last_seen_ms;
    if (req_q.now_ms < cur_q.last_seen_ms) gap_d = '0;
    else if (diff > 48'(GAP_MAX)) gap_d = GAP_MAX;
    else gap_d = diff[GAP_W-1:0];

    gap_sq   = 48'(gap_q) * 48'(gap_q);
    addr_new = !seen_q && (cur_q.addr_count < ADDR_CNT_W'(ADDR_SLOTS));
    upd      = cur_q;
    if (cur_q.conn_total != '0 && cur_q.gap_count != 16'hFFFF) begin
      upd.gap_count      = cur_q.gap_count + 16'd1;
      upd.gap_sum        = cur_q.gap_sum + 40'(gap_q);
      upd.gap_square_sum = cur_q.gap_square_sum + 64'(gap_sq);
    end
    upd.last_seen_ms = req_q.now_ms;
    if (cur_q.conn_total != 16'hFFFF) upd.conn_total = cur_q.conn_total + 16'd1;
    if (addr_new) upd.addr_count = cur_q.addr_count + ADDR_CNT_W'(1);
    upd.port_hit_mask = cur_q.port_hit_mask | hot_mask(req_q.dest_port_num);
  end

  assign stat_ra   = (state_q == S_LOOK) ? hit_idx : idx_q;
  assign stat_we   = state_q == S_UPD;
  assign addr_base = ADDR_IDX_W'(idx_q) * ADDR_IDX_W'(ADDR_SLOTS);
  assign addr_ra   = addr_base + ADDR_IDX_W'(ai_q);
  assign addr_wa   = addr_base + ADDR_IDX_W'(cur_q.addr_count);
  assign addr_we   = (state_q == S_UPD) && addr_new;

  // accesses are strictly ordered by the sequencer, so a write always lands
  // before any later read of the same entry
  always_ff @(posedge clk_i) begin
    if (stat_we) stat_mem[idx_q] <= upd;
    stat_rd_q <= stat_mem[stat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (addr_we) addr_mem[addr_wa] <= req_q.dest_addr;
    addr_rd_q <= addr_mem[addr_ra];
  end

  cbs_scorer u_scorer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_SCORE),
    .stat_i   (cur_q),
    .result_o (sc)
  );

  assign cand     = rem_q[j_q] && (!best_ok_q || key_q[j_q] < best_key_q);
  assign rem_left = rem_q & ~(PROC_SLOTS'(1) << best_idx_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_LOOK;
      S_LOOK: begin
        case (req_q.kind)
          KIND_TRACK: state_d = (hit_any || free_any) ? S_RD : S_EMIT;
          KIND_QUERY: state_d = hit_any ? S_RD : S_EMIT;
          KIND_FREE:  state_d = S_EMIT;
          default:    state_d = S_LCHK;
        endcase
      end
      S_LCHK:  state_d = valid_q[idx_q] ? S_RD : S_LADV;
      S_RD:    state_d = (req_q.kind == KIND_TRACK) ? S_ARD : S_SCORE;
      S_ARD:   state_d = (ai_q < cur_q.addr_count) ? S_ACMP : S_GAP;
      S_ACMP:  state_d = S_ARD;
      S_GAP:   state_d = S_UPD;
      S_UPD:   state_d = S_SCORE;
      S_SCORE: state_d = S_SWAIT;
      S_SWAIT: if (sc.done) state_d = (req_q.kind == KIND_LIST) ? S_LADV : S_EMIT;
      S_LADV: begin
        if (idx_q == LAST_IDX) state_d = (rem_q == '0) ? S_EMIT : S_SEL;
        else state_d = S_LCHK;
      end
      S_SEL:   if (j_q == LAST_IDX) state_d = S_LPICK;
      S_LPICK: state_d = S_EMIT;
      S_EMIT:  if (out_load) state_d = res_q.last ? S_IDLE : S_SEL;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      new_q       <= 1'b0;
      ai_q        <= '0;
      seen_q      <= 1'b0;
      j_q         <= '0;
      best_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOOK: begin
          if (req_q.kind == KIND_FREE && hit_any) valid_q[hit_idx] <= 1'b0;
          if (req_q.kind == KIND_LIST) idx_q <= '0;
          else idx_q <= hit_any ? hit_idx : free_idx;
          new_q <= (req_q.kind == KIND_TRACK) && !hit_any;
          rem_q <= '0;
        end
        S_RD: begin
          ai_q   <= '0;
          seen_q <= 1'b0;
        end
        S_ACMP: begin
          ai_q <= ai_q + ADDR_CNT_W'(1);
          if (addr_rd_q == req_q.dest_addr) seen_q <= 1'b1;
        end
        S_UPD: valid_q[idx_q] <= 1'b1;
        S_SWAIT: begin
          if (sc.done && req_q.kind == KIND_LIST) begin
            rem_q[idx_q] <= sc.score >= req_q.score_floor;
          end
        end
        S_LADV: begin
          if (idx_q != LAST_IDX) idx_q <= idx_q + PROC_W'(1);
          j_q       <= '0;
          best_ok_q <= 1'b0;
        end
        S_SEL: begin
          j_q <= j_q + PROC_W'(1);
          if (cand) best_ok_q <= 1'b1;
        end
        S_LPICK: begin
          rem_q[best_idx_q] <= 1'b0;
          j_q               <= '0;
          best_ok_q         <= 1'b0;
        end
        default: ;
      endcase
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (accept) req_q <= in_req_i;
      S_LOOK: begin
        case (req_q.kind)
          KIND_TRACK: res_q <= mk_res('0, req_q.proc_id, 1'b0, STATUS_FULL, 1'b1);
          KIND_FREE: begin
            res_q <= mk_res('0, req_q.proc_id, 1'b0,
                            hit_any ? STATUS_OK : STATUS_UNKNOWN, 1'b1);
          end
          default: res_q <= mk_res('0, req_q.proc_id, 1'b0, STATUS_UNKNOWN, 1'b1);
        endcase
      end
      S_RD:  cur_q <= new_q ? '0 : stat_rd_q;
      S_GAP: gap_q <= gap_d;
      S_UPD: begin
        cur_q         <= upd;
        key_q[idx_q]  <= req_q.proc_id;
      end
      S_SWAIT: begin
        if (sc.done) begin
          if (req_q.kind == KIND_LIST) begin
            lsc_q[idx_q] <= sc.score;
            lbc_q[idx_q] <= sc.beacon;
          end else begin
            res_q <= mk_res(sc.score, req_q.proc_id, sc.beacon, STATUS_OK, 1'b1);
          end
        end
      end
      S_LADV: res_q <= mk_res('0, '0, 1'b0, STATUS_NOMATCH, 1'b1);
      S_SEL: begin
        if (cand) begin
          best_idx_q <= j_q;
          best_key_q <= key_q[j_q];
          best_sc_q  <= lsc_q[j_q];
          best_bc_q  <= lbc_q[j_q];
        end
      end
      S_LPICK: res_q <= mk_res(best_sc_q, best_key_q, best_bc_q, STATUS_OK, rem_left == '0);
      S_EMIT:  if (out_load) out_q <= res_q;
      default: ;
    endcase
  end

  a_score_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc.done |-> state_q == S_SWAIT)
    else $error("scorer finished outside its wait state");

  a_score_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.score <= SCORE_W'(MAX_SCORE))
    else $error("result score above cap");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STATUS_OK) |-> (out_q.score == '0 && !out_q.beacon_seen))
    else $error("error result carries a score");

  a_valid_changes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q != $past(valid_q)) |-> ($past(state_q) == S_LOOK || $past(state_q) == S_UPD))
    else $error("table valid flags changed outside lookup or update");

endmodule
